[hw/rtl/sfc_pkg.sv]
// Package for the serial frame checker.
// Holds the transaction payload types, the error codes and the frame constants.
// No dependencies.
package sfc_pkg;

    localparam logic [7:0]  START_FIRST    = 8'h5A;
    localparam logic [7:0]  START_SECOND   = 8'h7E;
    localparam logic [15:0] FRAME_OVERHEAD = 16'd7;
    localparam logic [15:0] INDEX_MAX      = 16'hFFFF;

    localparam logic [15:0] POS_START_FIRST  = 16'd0;
    localparam logic [15:0] POS_START_SECOND = 16'd1;
    localparam logic [15:0] POS_ID           = 16'd2;
    localparam logic [15:0] POS_LEN_LOW      = 16'd4;
    localparam logic [15:0] POS_LEN_HIGH     = 16'd5;
    localparam logic [15:0] POS_PAYLOAD      = 16'd6;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SHORT    = 3'd1,
        ERR_START    = 3'd2,
        ERR_LENGTH   = 3'd3,
        ERR_CHECKSUM = 3'd4
    } sfc_err_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } sfc_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_payload;
        logic        frame_end;
        logic        frame_ok;
        sfc_err_t    error_code;
        logic [7:0]  packet_id;
        logic [15:0] payload_len;
    } sfc_out_t;

endpackage

[hw/rtl/sfc_in_if.sv]
// Handshake channel that carries received frame bytes.
// Depends on sfc_pkg for the payload type.
interface sfc_in_if
    import sfc_pkg::*;
();
    logic    valid;
    logic    ready;
    sfc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/sfc_out_if.sv]
// Handshake channel that carries per-byte check results.
// Depends on sfc_pkg for the payload type.
interface sfc_out_if
    import sfc_pkg::*;
();
    logic     valid;
    logic     ready;
    sfc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/sfc_frame_state.sv]
// Frame tracking state and per-byte check logic of the serial frame checker.
// Depends on sfc_pkg; the result is combinational from the state and the byte.
module sfc_frame_state
    import sfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  sfc_in_t  item,
    output sfc_out_t result
);

    logic [15:0] byte_index_reg, byte_index_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic        start_good_reg, start_good_next;
    logic [7:0]  held_id_reg, held_id_next;
    logic [15:0] declared_length_reg, declared_length_next;

    logic [15:0] pos;
    logic [7:0]  b;
    logic        start_ok;
    logic [7:0]  pid;
    logic [15:0] decl_len;
    logic [16:0] pos_plus_one;
    logic [15:0] count;
    sfc_err_t    err;

    assign pos          = byte_index_reg;
    assign b            = item.rx_byte;
    assign pos_plus_one = {1'b0, pos} + 17'd1;
    assign count        = (pos == INDEX_MAX) ? INDEX_MAX : pos_plus_one[15:0];

    always_comb
    begin
        start_ok = start_good_reg;
        if ((pos == POS_START_FIRST) && (b != START_FIRST))
        begin
            start_ok = 1'b0;
        end
        if ((pos == POS_START_SECOND) && (b != START_SECOND))
        begin
            start_ok = 1'b0;
        end
        pid = (pos == POS_ID) ? b : held_id_reg;
        decl_len = declared_length_reg;
        if (pos == POS_LEN_LOW)
        begin
            decl_len = {declared_length_reg[15:8], b};
        end
        else if (pos == POS_LEN_HIGH)
        begin
            decl_len = {b, declared_length_reg[7:0]};
        end
    end

    always_comb
    begin
        priority if (count < FRAME_OVERHEAD)
        begin
            err = ERR_SHORT;
        end
        else if (!start_ok)
        begin
            err = ERR_START;
        end
        else if (decl_len != count)
        begin
            err = ERR_LENGTH;
        end
        else if (b != running_sum_reg)
        begin
            err = ERR_CHECKSUM;
        end
        else
        begin
            err = ERR_NONE;
        end
    end

    always_comb
    begin
        result.out_byte   = b;
        result.is_payload = !item.last_byte && (pos >= POS_PAYLOAD)
                            && (pos_plus_one < {1'b0, decl_len});
        result.frame_end  = item.last_byte;
        result.packet_id  = pid;
        if (item.last_byte)
        begin
            result.error_code  = err;
            result.frame_ok    = (err == ERR_NONE);
            result.payload_len = (count >= FRAME_OVERHEAD) ? (count - FRAME_OVERHEAD) : 16'd0;
        end
        else
        begin
            result.error_code  = ERR_NONE;
            result.frame_ok    = 1'b0;
            result.payload_len = 16'd0;
        end
    end

    always_comb
    begin
        if (item.last_byte)
        begin
            byte_index_next      = 16'd0;
            running_sum_next     = 8'd0;
            start_good_next      = 1'b1;
            held_id_next         = 8'd0;
            declared_length_next = 16'd0;
        end
        else
        begin
            byte_index_next      = count;
            running_sum_next     = running_sum_reg + b;
            start_good_next      = start_ok;
            held_id_next         = pid;
            declared_length_next = decl_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg      <= 16'd0;
            running_sum_reg     <= 8'd0;
            start_good_reg      <= 1'b1;
            held_id_reg         <= 8'd0;
            declared_length_reg <= 16'd0;
        end
        else if (accept)
        begin
            byte_index_reg      <= byte_index_next;
            running_sum_reg     <= running_sum_next;
            start_good_reg      <= start_good_next;
            held_id_reg         <= held_id_next;
            declared_length_reg <= declared_length_next;
        end
    end

endmodule

[hw/rtl/sfc_result_buffer.sv]
// Result register with a skid stage for the serial frame checker.
// Depends on sfc_pkg and sfc_out_if; lets a new byte enter while a result is stalled.
module sfc_result_buffer
    import sfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  sfc_out_t  load_data,
    output logic      load_ready,
    sfc_out_if.source report
);

    logic     out_valid_reg;
    sfc_out_t out_data_reg;
    logic     skid_valid_reg;
    sfc_out_t skid_data_reg;
    logic     out_stalled;

    assign out_stalled  = out_valid_reg && !report.ready;
    assign load_ready   = !skid_valid_reg;
    assign report.valid = out_valid_reg;
    assign report.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_stalled)
        begin
            if (load)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_stalled)
        begin
            if (load)
            begin
                skid_data_reg <= load_data;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (load)
        begin
            out_data_reg <= load_data;
        end
    end

endmodule

[hw/rtl/serial_frame_checker.sv]
// Serial frame checker: checks received frames one byte per transaction.
// Each result is registered in the result register, or in the skid stage on a stall.
// Throughput: one byte per cycle while the skid stage is empty; the result register plus
// a one-entry skid stage keep the input open for one more transaction on a stall.
// Reset (rst_n, asynchronous, active low) clears the frame state and empties both stages.
module serial_frame_checker
    import sfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    sfc_in_if.sink   frame,
    sfc_out_if.source report
);

    logic     accept;
    logic     load_ready;
    sfc_out_t result;

    assign frame.ready = load_ready;
    assign accept      = frame.valid && load_ready;

    sfc_frame_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (frame.data),
        .result (result)
    );

    sfc_result_buffer u_buffer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .load_data  (result),
        .load_ready (load_ready),
        .report     (report)
    );

endmodule

[hw/rtl/sfc_checker.sv]
// Port-level assertions for the serial frame checker, bound to the top level.
// Depends on sfc_pkg for the error codes.
module sfc_checker
    import sfc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     frame_ready,
    input logic     report_valid,
    input logic     report_ready,
    input sfc_out_t report_data
);

    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=> report_valid && $stable(report_data))
        else $error("stalled result changed or vanished");

    a_full_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_ready |-> report_valid)
        else $error("input blocked with no result pending");

    a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> report_data.frame_ok
                         == (report_data.frame_end && (report_data.error_code == ERR_NONE)))
        else $error("frame_ok disagrees with error code");

    a_end_only_fields: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_data.frame_end
        |-> (report_data.error_code == ERR_NONE) && (report_data.payload_len == 16'd0))
        else $error("end-of-frame fields set on a non-final byte");

    a_payload_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report_data.is_payload |-> !report_data.frame_end)
        else $error("final byte marked as payload");

endmodule

bind serial_frame_checker sfc_checker u_sfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_ready  (frame.ready),
    .report_valid (report.valid),
    .report_ready (report.ready),
    .report_data  (report.data)
);
